// ===== rtl/core/kdef_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kdef_pkg: shared types and constants of the key debounce event FIFO
// Word formats, command and register codes, and ring and debounce sizing.
// ----------------------------------------------------------------------------
package kdef_pkg;

  localparam int FILTER_TICKS = 5;
  localparam int RING_DEPTH   = 16;
  localparam int KEY_TOTAL    = 4;
  localparam int HARD_KEYS    = 3;

  localparam int RING_AW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int DB_W    = $clog2(2 * FILTER_TICKS + 1);
  localparam int KEY_W   = $clog2(KEY_TOTAL);

  localparam logic [DB_W-1:0] DB_FT    = DB_W'(FILTER_TICKS);
  localparam logic [DB_W-1:0] DB_MAX   = DB_W'(2 * FILTER_TICKS);
  localparam logic [DB_W-1:0] DB_RESET = DB_W'(FILTER_TICKS / 2);

  localparam logic [RING_AW-1:0] RING_LAST = RING_AW'(RING_DEPTH - 1);
  localparam logic [KEY_W-1:0]   KEY_LAST  = KEY_W'(KEY_TOTAL - 1);

  // configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_HOLD_K1     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HOLD_K2     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HOLD_K3     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_HOLD_COMBO  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_REPEAT      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_LVLS = 3'd5;
  localparam int CFG_DATA_W = 32;

  localparam logic [15:0] HOLD_RESET       = 16'd100;
  localparam logic [15:0] HOLD_COMBO_RESET = 16'd200;
  localparam logic [31:0] REPEAT_RESET     = 32'd0;
  localparam logic [2:0]  ACTIVE_RESET     = 3'd2;

  // event code offsets within a key's group of three
  localparam logic [3:0] OFS_PRESS   = 4'd1;
  localparam logic [3:0] OFS_RELEASE = 4'd2;
  localparam logic [3:0] OFS_LONG    = 4'd3;
  localparam logic [3:0] CODE_NONE   = 4'd0;

  typedef enum logic [1:0] {
    CMD_TICK   = 2'd0,
    CMD_READ_A = 2'd1,
    CMD_READ_B = 2'd2,
    CMD_LOCK   = 2'd3
  } cmd_e;

  typedef struct packed {
    logic [1:0] cmd;
    logic [2:0] pin_levels;
  } in_word_t;

  typedef struct packed {
    logic [3:0] key_code;
    logic [3:0] key_states;
    logic       locked;
  } out_word_t;

  typedef struct packed {
    logic [KEY_TOTAL-1:0][15:0] hold_ticks;
    logic [31:0]                repeat_periods;
    logic [2:0]                 active_levels;
  } cfg_t;

  typedef struct packed {
    cmd_e                 op;
    logic [KEY_TOTAL-1:0] down;
  } job_t;

  function automatic logic [3:0] event_code(input logic [KEY_W-1:0] k,
                                            input logic [3:0] ofs);
    logic [3:0] base;
    base = 4'(k) + 4'(k) + 4'(k);
    return base + ofs;
  endfunction

endpackage

// ===== rtl/core/kdef_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kdef_front: command intake and classification
// Decodes each word into an operation and per-key down levels, and buffers
// it in a two-entry queue toward the sequencer.
// ----------------------------------------------------------------------------
module kdef_front import kdef_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  cfg_t     cfg_i,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  in_word_t in_data_i,
  output logic     job_valid_o,
  output job_t     job_o,
  input  logic     job_take_i
);

  job_t       slot_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;
  logic       push, pop;
  job_t       job_new;
  logic [HARD_KEYS-1:0] pin_act;

  always_comb begin
    pin_act      = ~(in_data_i.pin_levels ^ cfg_i.active_levels);
    job_new.op   = cmd_e'(in_data_i.cmd);
    job_new.down = {pin_act[1] & pin_act[2], pin_act};
  end

  assign in_stall_o  = (count_q == 2'd2);
  assign job_valid_o = (count_q != 2'd0);
  assign job_o       = slot_q[rd_ptr_q];

  assign push = in_valid_i && !in_stall_o;
  assign pop  = job_take_i && job_valid_o;

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= job_new;
    end
  end

endmodule

// ===== rtl/core/kdef_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kdef_back: key sequencer, event ring and readers
// Updates one key per cycle on a tick, plus an extra step for each key posting
// two events at the single ring write port; serves both readers, holds output word.
// ----------------------------------------------------------------------------
module kdef_back import kdef_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cfg_t      cfg_i,
  input  logic      job_valid_i,
  input  job_t      job_i,
  output logic      job_take_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_word_t out_data_o
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_KEY   = 3'd1;
  localparam logic [2:0] ST_KEY2  = 3'd2;
  localparam logic [2:0] ST_FIN   = 3'd3;
  localparam logic [2:0] ST_RDATA = 3'd4;

  logic [2:0]       state_q, state_d;
  logic [KEY_W-1:0] kidx_q, kidx_d;
  logic [KEY_TOTAL-1:0] down_q, down_d;
  logic [3:0]       ev2_q, ev2_d;

  logic [DB_W-1:0]      db_q  [KEY_TOTAL];
  logic [DB_W-1:0]      db_d  [KEY_TOTAL];
  logic [KEY_TOTAL-1:0] prs_q, prs_d;
  logic [15:0]          hc_q  [KEY_TOTAL];
  logic [15:0]          hc_d  [KEY_TOTAL];
  logic [7:0]           rc_q  [KEY_TOTAL];
  logic [7:0]           rc_d  [KEY_TOTAL];

  logic [RING_AW-1:0] wp_q, wp_d, rpa_q, rpa_d, rpb_q, rpb_d;
  logic               lock_q, lock_d;

  logic [3:0]         ring_q [RING_DEPTH];
  logic               mem_we, mem_re;
  logic [RING_AW-1:0] mem_raddr;
  logic [3:0]         mem_wdata, rdata_q;

  logic      out_valid_q, out_valid_d, out_load, out_free;
  out_word_t out_word_q;
  logic [3:0] out_code;

  // per-key evaluation for the key under the sequencer
  logic [DB_W-1:0] cnt, n_db;
  logic            prs, n_prs, dn;
  logic [15:0]     hc, n_hc, hc_inc, ht;
  logic [7:0]      rc, n_rc, rc_inc, per;
  logic            ev_press, ev_rel, ev_hold, ev_any, ev_two;
  logic [3:0]      hold_code, first_code;

  function automatic logic [RING_AW-1:0] ptr_inc(input logic [RING_AW-1:0] p);
    return (p == RING_LAST) ? '0 : p + RING_AW'(1);
  endfunction

  always_comb begin
    cnt    = db_q[kidx_q];
    prs    = prs_q[kidx_q];
    hc     = hc_q[kidx_q];
    rc     = rc_q[kidx_q];
    dn     = down_q[kidx_q];
    ht     = cfg_i.hold_ticks[kidx_q];
    per    = cfg_i.repeat_periods[{kidx_q, 3'b000} +: 8];
    hc_inc = hc + 16'd1;
    rc_inc = rc + 8'd1;
    n_db      = cnt;
    n_prs     = prs;
    n_hc      = hc;
    n_rc      = rc;
    ev_press  = 1'b0;
    ev_rel    = 1'b0;
    ev_hold   = 1'b0;
    hold_code = event_code(kidx_q, OFS_LONG);
    if (dn) begin
      if (cnt < DB_FT) begin
        n_db = DB_FT;
      end else if (cnt < DB_MAX) begin
        n_db = cnt + DB_W'(1);
      end else begin
        if (!prs) begin
          n_prs    = 1'b1;
          ev_press = 1'b1;
        end
        if (ht != 16'd0) begin
          if (hc < ht) begin
            n_hc = hc_inc;
            if (hc_inc == ht) begin
              ev_hold = 1'b1;
            end
          end else if (per != 8'd0) begin
            if (rc_inc >= per) begin
              n_rc      = 8'd0;
              ev_hold   = 1'b1;
              hold_code = event_code(kidx_q, OFS_PRESS);
            end else begin
              n_rc = rc_inc;
            end
          end
        end
      end
    end else begin
      if (cnt > DB_FT) begin
        n_db = DB_FT;
      end else if (cnt != '0) begin
        n_db = cnt - DB_W'(1);
      end else if (prs) begin
        n_prs  = 1'b0;
        ev_rel = 1'b1;
      end
      n_hc = 16'd0;
      n_rc = 8'd0;
    end
    ev_any = ev_press | ev_rel | ev_hold;
    ev_two = ev_press & ev_hold;
    if (ev_press) begin
      first_code = event_code(kidx_q, OFS_PRESS);
    end else if (ev_rel) begin
      first_code = event_code(kidx_q, OFS_RELEASE);
    end else begin
      first_code = hold_code;
    end
  end

  assign out_free   = !out_valid_q || !out_stall_i;
  assign job_take_o = (state_q == ST_IDLE) && job_valid_i && out_free;

  always_comb begin
    state_d   = state_q;
    kidx_d    = kidx_q;
    down_d    = down_q;
    ev2_d     = ev2_q;
    db_d      = db_q;
    prs_d     = prs_q;
    hc_d      = hc_q;
    rc_d      = rc_q;
    wp_d      = wp_q;
    rpa_d     = rpa_q;
    rpb_d     = rpb_q;
    lock_d    = lock_q;
    mem_we    = 1'b0;
    mem_wdata = first_code;
    mem_re    = 1'b0;
    mem_raddr = rpa_q;
    out_load  = 1'b0;
    out_code  = CODE_NONE;

    unique case (state_q)
      ST_IDLE: begin
        if (job_take_o) begin
          unique case (job_i.op)
            CMD_TICK: begin
              down_d  = job_i.down;
              kidx_d  = '0;
              state_d = ST_KEY;
            end
            CMD_READ_A: begin
              if (rpa_q != wp_q) begin
                mem_re    = 1'b1;
                mem_raddr = rpa_q;
                rpa_d     = ptr_inc(rpa_q);
                state_d   = ST_RDATA;
              end else begin
                out_load = 1'b1;
              end
            end
            CMD_READ_B: begin
              if (rpb_q != wp_q) begin
                mem_re    = 1'b1;
                mem_raddr = rpb_q;
                rpb_d     = ptr_inc(rpb_q);
                state_d   = ST_RDATA;
              end else begin
                out_load = 1'b1;
              end
            end
            CMD_LOCK: begin
              lock_d   = 1'b1;
              rpa_d    = wp_q;
              out_load = 1'b1;
            end
            default: ;
          endcase
        end
      end
      ST_KEY: begin
        db_d[kidx_q]  = n_db;
        prs_d[kidx_q] = n_prs;
        hc_d[kidx_q]  = n_hc;
        rc_d[kidx_q]  = n_rc;
        mem_we        = ev_any;
        if (ev_any) begin
          wp_d = ptr_inc(wp_q);
        end
        if (ev_two) begin
          ev2_d   = hold_code;
          state_d = ST_KEY2;
        end else if (kidx_q == KEY_LAST) begin
          state_d = ST_FIN;
        end else begin
          kidx_d = kidx_q + KEY_W'(1);
        end
      end
      ST_KEY2: begin
        mem_we    = 1'b1;
        mem_wdata = ev2_q;
        wp_d      = ptr_inc(wp_q);
        if (kidx_q == KEY_LAST) begin
          state_d = ST_FIN;
        end else begin
          kidx_d  = kidx_q + KEY_W'(1);
          state_d = ST_KEY;
        end
      end
      ST_FIN: begin
        if (lock_q) begin
          rpa_d = wp_q;
          if (prs_q[HARD_KEYS-1:0] == '0) begin
            lock_d = 1'b0;
          end
        end
        out_load = 1'b1;
        state_d  = ST_IDLE;
      end
      ST_RDATA: begin
        out_code = rdata_q;
        out_load = 1'b1;
        state_d  = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      kidx_q      <= '0;
      prs_q       <= '0;
      wp_q        <= '0;
      rpa_q       <= '0;
      rpb_q       <= '0;
      lock_q      <= 1'b0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < KEY_TOTAL; i++) begin
        db_q[i] <= DB_RESET;
        hc_q[i] <= 16'd0;
        rc_q[i] <= 8'd0;
      end
    end else begin
      state_q     <= state_d;
      kidx_q      <= kidx_d;
      prs_q       <= prs_d;
      wp_q        <= wp_d;
      rpa_q       <= rpa_d;
      rpb_q       <= rpb_d;
      lock_q      <= lock_d;
      out_valid_q <= out_valid_d;
      db_q        <= db_d;
      hc_q        <= hc_d;
      rc_q        <= rc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    down_q <= down_d;
    ev2_q  <= ev2_d;
    if (out_load) begin
      out_word_q.key_code   <= out_code;
      out_word_q.key_states <= prs_q;
      out_word_q.locked     <= lock_d;
    end
  end

  // event ring: one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      ring_q[wp_q] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= ring_q[mem_raddr];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_word_q;

endmodule

// ===== rtl/core/key_debounce_event_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// key_debounce_event_fifo: debounced keys with a shared two-reader event ring
// Configuration registers, command intake and the key/ring sequencer.
// ----------------------------------------------------------------------------
// Each input word is a scan tick, a read through reader A or B, or a lock,
// and each yields exactly one output word. A tick walks the four keys one per
// cycle through the sequencer, with an extra ST_KEY2 step for each key that
// posts two events (single ring write port), and ends in ST_FIN. A non-empty
// read passes through ST_RDATA; an empty read and a lock load the output word
// from idle. The two-word intake queue takes new words while the sequencer
// works and the output word waits. The ring has 16 entries, overwritten on overrun.
module key_debounce_event_fifo import kdef_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  in_word_t              in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output out_word_t             out_data_o
);

  cfg_t cfg_q, cfg_d;
  logic job_valid, job_take;
  job_t job;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_HOLD_K1:     cfg_d.hold_ticks[0]  = cfg_wdata_i[15:0];
        CFG_HOLD_K2:     cfg_d.hold_ticks[1]  = cfg_wdata_i[15:0];
        CFG_HOLD_K3:     cfg_d.hold_ticks[2]  = cfg_wdata_i[15:0];
        CFG_HOLD_COMBO:  cfg_d.hold_ticks[3]  = cfg_wdata_i[15:0];
        CFG_REPEAT:      cfg_d.repeat_periods = cfg_wdata_i;
        CFG_ACTIVE_LVLS: cfg_d.active_levels  = cfg_wdata_i[2:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.hold_ticks[0]  <= HOLD_RESET;
      cfg_q.hold_ticks[1]  <= HOLD_RESET;
      cfg_q.hold_ticks[2]  <= HOLD_RESET;
      cfg_q.hold_ticks[3]  <= HOLD_COMBO_RESET;
      cfg_q.repeat_periods <= REPEAT_RESET;
      cfg_q.active_levels  <= ACTIVE_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  kdef_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .job_valid_o (job_valid),
    .job_o       (job),
    .job_take_i  (job_take)
  );

  kdef_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .job_valid_i (job_valid),
    .job_i       (job),
    .job_take_o  (job_take),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ===== verif/kdef_event_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kdef_event_checker: scoreboard for the key debounce event FIFO
// Mirrors the register writes, predicts the output word of every accepted
// input word from its own copy of the debounce, hold, repeat, ring and lock
// state, and compares each accepted output word field by field with the
// oldest prediction. Reports the queue depth and the mismatch count.
// ----------------------------------------------------------------------------
module kdef_event_checker import kdef_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                  in_valid_i,
  input  logic                  in_stall_i,
  input  in_word_t              in_data_i,
  input  logic                  out_valid_i,
  input  logic                  out_stall_i,
  input  out_word_t             out_data_i,
  output int                    fail_count_o,
  output int                    pending_o
);

  localparam int COMBO = KEY_TOTAL - 1;

  cfg_t               regs;
  logic [7:0]         db_cnt   [KEY_TOTAL];
  logic               key_dn   [KEY_TOTAL];
  logic [15:0]        hold_cnt [KEY_TOTAL];
  logic [7:0]         rep_cnt  [KEY_TOTAL];
  logic [3:0]         ring     [RING_DEPTH];
  logic [RING_AW-1:0] wr_ptr;
  logic [RING_AW-1:0] rd_a;
  logic [RING_AW-1:0] rd_b;
  logic               lock_q;
  out_word_t          expected_q[$];
  int                 mismatches = 0;

  assign fail_count_o = mismatches;

  task automatic clear_model();
    regs.hold_ticks[0] = HOLD_RESET;
    regs.hold_ticks[1] = HOLD_RESET;
    regs.hold_ticks[2] = HOLD_RESET;
    regs.hold_ticks[3] = HOLD_COMBO_RESET;
    regs.repeat_periods = REPEAT_RESET;
    regs.active_levels = ACTIVE_RESET;
    for (int k = 0; k < KEY_TOTAL; k++) begin
      db_cnt[k] = 8'(FILTER_TICKS / 2);
      key_dn[k] = 1'b0;
      hold_cnt[k] = '0;
      rep_cnt[k] = '0;
    end
    for (int i = 0; i < RING_DEPTH; i++) ring[i] = CODE_NONE;
    wr_ptr = '0;
    rd_a = '0;
    rd_b = '0;
    lock_q = 1'b0;
  endtask

  task automatic apply_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    case (idx)
      CFG_HOLD_K1:     regs.hold_ticks[0] = val[15:0];
      CFG_HOLD_K2:     regs.hold_ticks[1] = val[15:0];
      CFG_HOLD_K3:     regs.hold_ticks[2] = val[15:0];
      CFG_HOLD_COMBO:  regs.hold_ticks[3] = val[15:0];
      CFG_REPEAT:      regs.repeat_periods = val[31:0];
      CFG_ACTIVE_LVLS: regs.active_levels = val[2:0];
      default: ;
    endcase
  endtask

  function automatic void post_code(input logic [3:0] code);
    ring[wr_ptr] = code;
    wr_ptr = (wr_ptr == RING_LAST) ? '0 : wr_ptr + 1'b1;
  endfunction

  function automatic logic [3:0] take_code(input logic from_b);
    logic [RING_AW-1:0] ptr;
    logic [3:0] code;
    ptr = from_b ? rd_b : rd_a;
    if (ptr == wr_ptr) return CODE_NONE;
    code = ring[ptr];
    ptr = (ptr == RING_LAST) ? '0 : ptr + 1'b1;
    if (from_b) rd_b = ptr;
    else rd_a = ptr;
    return code;
  endfunction

  function automatic void track_key(input int k, input logic down);
    logic [3:0] base;
    logic [7:0] period;
    base = 4'(3 * k);
    period = regs.repeat_periods[8*k +: 8];
    if (down) begin
      if (db_cnt[k] < FILTER_TICKS) begin
        db_cnt[k] = 8'(FILTER_TICKS);
      end else if (db_cnt[k] < 2 * FILTER_TICKS) begin
        db_cnt[k] = db_cnt[k] + 1'b1;
      end else begin
        if (!key_dn[k]) begin
          key_dn[k] = 1'b1;
          post_code(base + OFS_PRESS);
        end
        if (regs.hold_ticks[k] != 0) begin
          if (hold_cnt[k] < regs.hold_ticks[k]) begin
            hold_cnt[k] = hold_cnt[k] + 1'b1;
            if (hold_cnt[k] == regs.hold_ticks[k]) post_code(base + OFS_LONG);
          end else if (period != 0) begin
            rep_cnt[k] = rep_cnt[k] + 1'b1;
            if (rep_cnt[k] >= period) begin
              rep_cnt[k] = '0;
              post_code(base + OFS_PRESS);
            end
          end
        end
      end
    end else begin
      if (db_cnt[k] > FILTER_TICKS) begin
        db_cnt[k] = 8'(FILTER_TICKS);
      end else if (db_cnt[k] != 0) begin
        db_cnt[k] = db_cnt[k] - 1'b1;
      end else if (key_dn[k]) begin
        key_dn[k] = 1'b0;
        post_code(base + OFS_RELEASE);
      end
      hold_cnt[k] = '0;
      rep_cnt[k] = '0;
    end
  endfunction

  function automatic out_word_t predict_word(input in_word_t w);
    out_word_t r;
    logic [2:0] on;
    r.key_code = CODE_NONE;
    on = ~(w.pin_levels ^ regs.active_levels);
    case (cmd_e'(w.cmd))
      CMD_TICK: begin
        for (int k = 0; k < HARD_KEYS; k++) track_key(k, on[k]);
        track_key(COMBO, on[1] && on[2]);
        if (lock_q) begin
          rd_a = wr_ptr;
          if (!key_dn[0] && !key_dn[1] && !key_dn[2]) lock_q = 1'b0;
        end
      end
      CMD_READ_A: r.key_code = take_code(1'b0);
      CMD_READ_B: r.key_code = take_code(1'b1);
      default: begin
        lock_q = 1'b1;
        rd_a = wr_ptr;
      end
    endcase
    for (int k = 0; k < KEY_TOTAL; k++) r.key_states[k] = key_dn[k];
    r.locked = lock_q;
    return r;
  endfunction

  task automatic check_word(input out_word_t got);
    out_word_t want;
    if (expected_q.size() == 0) begin
      $error("output word %h with nothing expected", got);
      mismatches++;
      return;
    end
    want = expected_q.pop_front();
    if (got.key_code !== want.key_code) begin
      $error("key_code: expected %0d, got %0d", want.key_code, got.key_code);
      mismatches++;
    end
    if (got.key_states !== want.key_states) begin
      $error("key_states: expected %b, got %b", want.key_states, got.key_states);
      mismatches++;
    end
    if (got.locked !== want.locked) begin
      $error("locked: expected %b, got %b", want.locked, got.locked);
      mismatches++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_model();
      expected_q.delete();
      pending_o <= 0;
    end else begin
      if (cfg_we_i) apply_reg(cfg_idx_i, cfg_wdata_i);
      if (out_valid_i && !out_stall_i) check_word(out_data_i);
      if (in_valid_i && !in_stall_i) expected_q.push_back(predict_word(in_data_i));
      pending_o <= expected_q.size();
    end
  end

endmodule

// ===== verif/tb_key_debounce_event_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_key_debounce_event_fifo: testbench top for the key debounce event FIFO
// Drives a directed opening (lock on idle keys, press with long press on the
// same tick, reads on both readers, lock while held, release), then segments
// of random key runs with bounce, reads and locks under several register
// settings and handshake idling patterns. The checker judges every word.
// ----------------------------------------------------------------------------
module tb_key_debounce_event_fifo;
  import kdef_pkg::*;

  localparam int STUCK_LIMIT   = 4000;
  localparam int SETTLE_CYCLES = 16;
  localparam int SEGMENTS      = 6;
  localparam int SEGMENT_WORDS = 320;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  in_word_t              in_data = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_word_t             out_data;
  int                    fail_count;
  int                    pending;
  int                    stuck_cycles = 0;
  int                    tx_idle_pct = 0;
  int                    rx_idle_pct = 0;
  int                    run_left = 0;
  logic [2:0]            pattern = '0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  key_debounce_event_fifo uut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  kdef_event_checker checker_i (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_wdata_i  (cfg_wdata),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .in_data_i    (in_data),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .out_data_i   (out_data),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < rx_idle_pct);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
      stuck_cycles <= 0;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
    if (stuck_cycles >= STUCK_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic put_reg(input logic [CFG_IDX_W-1:0] idx,
                         input logic [CFG_DATA_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= val;
    @(posedge clk);
  endtask

  // upper data bits carry junk, the registers must ignore them
  task automatic load_settings(input cfg_t s);
    put_reg(CFG_HOLD_K1, {16'($urandom), s.hold_ticks[0]});
    put_reg(CFG_HOLD_K2, {16'($urandom), s.hold_ticks[1]});
    put_reg(CFG_HOLD_K3, {16'($urandom), s.hold_ticks[2]});
    put_reg(CFG_HOLD_COMBO, {16'($urandom), s.hold_ticks[3]});
    put_reg(CFG_REPEAT, s.repeat_periods);
    put_reg(CFG_ACTIVE_LVLS, {29'($urandom), s.active_levels});
    cfg_we <= 1'b0;
  endtask

  task automatic send_word(input cmd_e op, input logic [2:0] pins);
    in_word_t w;
    w.cmd = op;
    w.pin_levels = pins;
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= w;
    do @(posedge clk); while (!(in_valid && !in_stall));
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic cfg_t segment_settings(input int seg);
    cfg_t s;
    case (seg)
      1: begin
        s.hold_ticks[0] = 16'hFFFF;
        s.hold_ticks[1] = 16'd0;
        s.hold_ticks[2] = 16'd1;
        s.hold_ticks[3] = 16'hFFFF;
        s.repeat_periods = 32'hFFFF_FFFF;
        s.active_levels = 3'b111;
      end
      2: begin
        for (int k = 0; k < KEY_TOTAL; k++) s.hold_ticks[k] = 16'd1;
        s.repeat_periods = 32'h0101_0101;
        s.active_levels = 3'b000;
      end
      3: begin
        for (int k = 0; k < KEY_TOTAL; k++) s.hold_ticks[k] = 16'd0;
        s.repeat_periods = 32'd0;
        s.active_levels = 3'($urandom);
      end
      default: begin
        for (int k = 0; k < KEY_TOTAL; k++) s.hold_ticks[k] = 16'($urandom_range(1, 12));
        for (int k = 0; k < KEY_TOTAL; k++) s.repeat_periods[8*k +: 8] = 8'($urandom_range(4));
        s.active_levels = 3'($urandom);
      end
    endcase
    return s;
  endfunction

  // mostly held key patterns, with one-tick bounce and short runs as noise
  task automatic random_word();
    int r;
    logic [2:0] pins;
    r = $urandom_range(99);
    if (r < 2) begin
      send_word(CMD_LOCK, 3'($urandom));
    end else if (r < 17) begin
      send_word(CMD_READ_A, 3'($urandom));
    end else if (r < 27) begin
      send_word(CMD_READ_B, 3'($urandom));
    end else begin
      if (run_left == 0) begin
        pattern = 3'($urandom);
        run_left = ($urandom_range(3) == 0) ? $urandom_range(1, 6) : $urandom_range(8, 40);
      end
      run_left--;
      pins = pattern;
      if ($urandom_range(99) < 5) pins[$urandom_range(2)] = ~pins[$urandom_range(2)];
      send_word(CMD_TICK, pins);
    end
  endtask

  initial begin
    cfg_t s;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: key 1 with hold of one tick, all pins high count as pressed
    tx_idle_pct <= 8;
    rx_idle_pct <= 64;
    s = segment_settings(0);
    s.hold_ticks[0] = 16'd1;
    s.hold_ticks[1] = HOLD_RESET;
    s.hold_ticks[2] = HOLD_RESET;
    s.hold_ticks[3] = HOLD_COMBO_RESET;
    s.repeat_periods = REPEAT_RESET;
    s.active_levels = 3'b111;
    load_settings(s);
    send_word(CMD_READ_A, 3'b000);
    send_word(CMD_READ_B, 3'b111);
    send_word(CMD_LOCK, 3'b000);
    send_word(CMD_TICK, 3'b000);
    repeat (7) send_word(CMD_TICK, 3'b111);
    send_word(CMD_READ_A, 3'b000);
    send_word(CMD_READ_A, 3'b000);
    send_word(CMD_READ_B, 3'b000);
    send_word(CMD_LOCK, 3'b111);
    send_word(CMD_TICK, 3'b111);
    send_word(CMD_READ_A, 3'b000);
    repeat (7) send_word(CMD_TICK, 3'b000);
    send_word(CMD_READ_B, 3'b000);

    for (int seg = 0; seg < SEGMENTS; seg++) begin
      drain();
      tx_idle_pct <= (seg < 2) ? 8 : (seg < 4) ? 64 : 0;
      rx_idle_pct <= (seg < 2) ? 64 : (seg < 4) ? 8 : 0;
      load_settings(segment_settings(seg));
      repeat (SEGMENT_WORDS) random_word();
    end

    drain();
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
